// File: rtl/tcw_pkg.sv
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tcw_pkg;

  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  localparam int ROW_W    = $clog2(ROWS);
  localparam int COL_W    = $clog2(COLS);
  localparam int PTR_W    = $clog2(CELLS + 1);
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 11;
  localparam int CURPOS_W = 11;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0700;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;

  // Register index taken from paddr[2]
  localparam logic REG_ATTR = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ_WAIT,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_CR,
    CUR_NEWLINE,
    CUR_ADVANCE,
    CUR_HOME
  } cur_op_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_PUT,
    MEM_RD_CELL,
    MEM_RD_SCROLL,
    MEM_WR_SCROLL,
    MEM_FILL,
    MEM_INIT
  } mem_op_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC
  } ptr_op_t;

  typedef struct packed {
    logic    load_item;
    cur_op_t cur_op;
    mem_op_t mem_op;
    ptr_op_t ptr_op;
    logic    set_scrolled;
    logic    cap_cell;
    logic    load_out;
  } tcw_cmd_t;

  typedef struct packed {
    op_t  op;
    logic is_cr;
    logic is_lf;
    logic is_print;
    logic last_row;
    logic last_col;
    logic ptr_move_end;
    logic ptr_end;
    logic out_free;
  } tcw_sts_t;

endpackage

// File: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcw_ctrl.sv
// Controller state machine: sequences put, clear, read, scroll and the power-up fill.
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   need_scroll;

  assign need_scroll = sts.last_row && (sts.is_lf || (sts.is_print && sts.last_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (sts.ptr_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (sts.op)
          OP_PUT:   state_next = need_scroll ? ST_SCROLL_RD : ST_DONE;
          OP_CLEAR: state_next = ST_FILL;
          OP_READ:  state_next = ST_READ_WAIT;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_SCROLL_RD: state_next = ST_SCROLL_WR;
      ST_SCROLL_WR: begin
        state_next = sts.ptr_move_end ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        if (sts.ptr_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.cur_op   = CUR_HOLD;
    cmd.mem_op   = MEM_NONE;
    cmd.ptr_op   = PTR_HOLD;
    s_tready     = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.mem_op = MEM_INIT;
        cmd.ptr_op = PTR_INC;
      end
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
      end
      ST_EXEC: begin
        case (sts.op)
          OP_PUT: begin
            if (sts.is_cr) begin
              cmd.cur_op = CUR_CR;
            end else if (sts.is_lf) begin
              cmd.cur_op = CUR_NEWLINE;
            end else if (sts.is_print) begin
              cmd.cur_op = CUR_ADVANCE;
              cmd.mem_op = MEM_PUT;
            end
            if (need_scroll) begin
              cmd.set_scrolled = 1'b1;
              cmd.ptr_op       = PTR_ZERO;
            end
          end
          OP_CLEAR: begin
            cmd.cur_op = CUR_HOME;
            cmd.ptr_op = PTR_ZERO;
          end
          OP_READ: cmd.mem_op = MEM_RD_CELL;
          default: cmd.mem_op = MEM_NONE;
        endcase
      end
      ST_READ_WAIT: cmd.cap_cell = 1'b1;
      ST_SCROLL_RD: cmd.mem_op = MEM_RD_SCROLL;
      ST_SCROLL_WR: begin
        cmd.mem_op = MEM_WR_SCROLL;
        cmd.ptr_op = PTR_INC;
      end
      ST_FILL: begin
        cmd.mem_op = MEM_FILL;
        cmd.ptr_op = PTR_INC;
      end
      ST_DONE: cmd.load_out = sts.out_free;
      default: cmd.mem_op = MEM_NONE;
    endcase
  end

endmodule

// File: rtl/tcw_dp.sv
// Datapath: item registers, cursor, sweep pointer, screen memory and output register.
module tcw_dp
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tcw_cmd_t            cmd,
  output tcw_sts_t            sts,
  input  logic [OP_W-1:0]     item_op,
  input  logic [CHAR_W-1:0]   item_char,
  input  logic [IDX_W-1:0]    item_idx,
  input  logic [ATTR_W-1:0]   attr,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata
);

  localparam int AW = $clog2(CELLS);

  op_t               op;
  logic [CHAR_W-1:0] ch;
  logic [AW-1:0]     rd_addr;
  logic              rd_oor;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [PTR_W-1:0]  ptr;
  logic              scrolled;
  logic [CELL_W-1:0] cell_data;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CELL_W-1:0] rdata;
  logic [AW-1:0]     cur_pos;
  logic              last_row;
  logic              last_col;

  assign last_row = (row == ROW_W'(ROWS - 1));
  assign last_col = (col == COL_W'(COLS - 1));
  assign cur_pos  = AW'(row) * AW'(COLS) + AW'(col);

  // Latch the accepted item; out-of-range reads return zero
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op      <= op_t'(item_op);
      ch      <= item_char;
      rd_oor  <= (item_idx >= IDX_W'(CELLS));
      rd_addr <= (item_idx >= IDX_W'(CELLS)) ? '0 : item_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_CR: col <= '0;
        CUR_NEWLINE: begin
          col <= '0;
          if (!last_row) row <= row + 1'b1;
        end
        CUR_ADVANCE: begin
          if (!last_col) begin
            col <= col + 1'b1;
          end else begin
            col <= '0;
            if (!last_row) row <= row + 1'b1;
          end
        end
        CUR_HOME: begin
          row <= '0;
          col <= '0;
        end
        default: row <= row;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (cmd.ptr_op)
        PTR_ZERO: ptr <= '0;
        PTR_INC:  ptr <= ptr + 1'b1;
        default:  ptr <= ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      scrolled  <= 1'b0;
      cell_data <= '0;
    end else begin
      if (cmd.set_scrolled) scrolled <= 1'b1;
      if (cmd.cap_cell) cell_data <= rd_oor ? '0 : rdata;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = {attr, CHAR_W'(0)};
    raddr = ptr[AW-1:0];
    case (cmd.mem_op)
      MEM_PUT: begin
        we    = 1'b1;
        waddr = cur_pos;
        wdata = {attr, ch};
      end
      MEM_RD_CELL:   raddr = rd_addr;
      MEM_RD_SCROLL: raddr = ptr[AW-1:0] + AW'(COLS);
      MEM_WR_SCROLL: begin
        we    = 1'b1;
        wdata = rdata;
      end
      MEM_FILL: we = 1'b1;
      MEM_INIT: begin
        we    = 1'b1;
        wdata = RESET_CELL;
      end
      default: we = 1'b0;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= M_DATA_W'({scrolled, cell_data, CURPOS_W'(cur_pos)});
    end
  end

  always_comb begin
    sts.op           = op;
    sts.is_cr        = (ch == CHAR_CR);
    sts.is_lf        = (ch == CHAR_LF);
    sts.is_print     = (ch >= PRINT_LO) && (ch <= PRINT_HI);
    sts.last_row     = last_row;
    sts.last_col     = last_col;
    sts.ptr_move_end = (ptr == PTR_W'(CELLS - COLS - 1));
    sts.ptr_end      = (ptr == PTR_W'(CELLS - 1));
    sts.out_free     = !m_tvalid || m_tready;
  end

endmodule

// File: rtl/text_console_writer_core.sv
// Top level of the text console writer: stream ports, APB attribute register, core wiring.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the opcode (put character,
//   clear screen, read cell) and s_tdata the character byte and the cell index. Each
//   word yields exactly one result word on m_tvalid/m_tready holding the cursor
//   position after the operation, the cell contents (read only) and a scroll flag.
//   The attribute byte for written, cleared and scroll-filled cells sits in an APB
//   register at address 0 (reset 0x07); change it only while the block is idle.
// Sequencing:
//   A word is accepted in the idle state and executes in the next cycle; its result
//   is loaded in the done state once the output register is free, and no new word is
//   accepted before then. A read adds a wait state for the registered memory read.
//   Scrolling copies the screen cell by cell, a read state and a write state per cell,
//   through the single-port-pair screen RAM and then fills the bottom row.
//   A clear fills all ROWS*COLS cells at one per cycle.
// Reset:
//   rst (synchronous) homes the cursor, resets the attribute to 0x07, then sweeps the
//   screen RAM writing 0x0700 into all 2000 cells; s_tready stays low during the sweep.
//   APB writes are taken throughout.
// Stalls:
//   The result waits in the output register while m_tready is low; the next word can
//   still be accepted and executed, and its result is held until the register frees.
module text_console_writer_core
  import tcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  // Input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // [7:0] char_code, [18:8] cell_index, rest zero
  input  logic [OP_W-1:0]     s_tuser,  // [1:0] opcode
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // [10:0] cursor_position, [26:11] cell_value,
                                        // [27] scrolled, rest zero
);

  logic [ATTR_W-1:0] attr;
  tcw_cmd_t          cmd;
  tcw_sts_t          sts;

  // APB: single attribute register, no wait states
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ATTR)) begin
      attr <= pwdata[ATTR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ATTR) ? APB_DW'(attr) : '0;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item_op   (s_tuser),
    .item_char (s_tdata[CHAR_W-1:0]),
    .item_idx  (s_tdata[CHAR_W +: IDX_W]),
    .attr      (attr),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: rtl/tcw_chk.sv
// Port-level checker for the text console writer, bound to the top level.
module tcw_chk
  import tcw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // A held result must not drop before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // The screen sweep after reset keeps the input closed
  a_init_closed: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input open during reset sweep");

  // An accepted word occupies the engine for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // Only reads return cell data, and reads never scroll
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[26:11] == '0)
    else $error("scrolled result carries cell data");

  // The cursor always lies on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:0] < CURPOS_W'(CELLS))
    else $error("cursor position off screen");

endmodule

bind text_console_writer_core tcw_chk u_tcw_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/testbench.sv
// Self-checking testbench for the text console writer core.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int                CYCLE_LIMIT = 20_000_000;
  localparam int                LONG_HOLD   = 3000;
  localparam int                HOLD_AFTER  = 300;
  localparam int                DRAIN_WAIT  = 64;
  localparam logic [APB_AW-1:0] ATTR_ADDR   = '0;  // register 0 at byte address 0

  typedef struct packed {
    op_t              op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_word_t;

  typedef struct packed {
    logic [CURPOS_W-1:0] cursor;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;
  } console_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [APB_DW-1:0]   pwdata   = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [OP_W-1:0]     s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  text_console_writer_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] char_code, [18:8] cell_index, rest zero
    .s_tuser  (s_tuser),   // [1:0] opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [10:0] cursor_position, [26:11] cell_value, [27] scrolled
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Console shadow: screen, cursor and attribute as the block should hold them
  logic [CELL_W-1:0] screen_copy [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] attr_now;

  console_word_t   words_to_send [$];
  console_result_t pending_results [$];
  int              mismatches   = 0;
  int              results_seen = 0;
  int              cycle_count  = 0;

  // Scroll the screen up one row, fill the bottom row with the blank attribute cell
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLS; i++)
      screen_copy[i] = screen_copy[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++)
      screen_copy[i] = {attr_now, 8'h00};
  endfunction

  function automatic logic new_line();
    cur_col = 0;
    if (cur_row < ROWS - 1) begin
      cur_row++;
      return 1'b0;
    end
    scroll_screen();
    return 1'b1;
  endfunction

  // Advance the console shadow by one word and return the result it should produce
  function automatic console_result_t console_step(console_word_t w);
    console_result_t r;
    r = '0;
    case (w.op)
      OP_PUT: begin
        if (w.ch == CHAR_CR) begin
          cur_col = 0;
        end else if (w.ch == CHAR_LF) begin
          r.scrolled = new_line();
        end else if (w.ch >= PRINT_LO && w.ch <= PRINT_HI) begin
          screen_copy[cur_row * COLS + cur_col] = {attr_now, w.ch};
          if (cur_col < COLS - 1) cur_col++;
          else r.scrolled = new_line();
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_copy[i] = {attr_now, 8'h00};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (w.idx < CELLS) r.cell_value = screen_copy[w.idx];
      end
      default: ;
    endcase
    r.cursor = CURPOS_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic void queue_word(op_t op, int ch, int idx);
    console_word_t w;
    w.op  = op;
    w.ch  = CHAR_W'(ch);
    w.idx = IDX_W'(idx);
    words_to_send.push_back(w);
  endfunction

  // Mostly lines of text with random content, some reads, noise and rare clears.
  // Ignored bytes do not count toward the word budget.
  task automatic queue_random_words(int budget);
    int made;
    int pick;
    int len;
    int ch;
    made = 0;
    while (made < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
        for (int j = 0; j < len; j++) begin
          queue_word(OP_PUT, $urandom_range(PRINT_LO, PRINT_HI), $urandom_range(0, 2047));
          made++;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          queue_word(OP_PUT, CHAR_CR, $urandom_range(0, 2047));
          queue_word(OP_PUT, CHAR_LF, $urandom_range(0, 2047));
          made += 2;
        end else if (pick < 9) begin
          queue_word(OP_PUT, CHAR_LF, $urandom_range(0, 2047));
          made++;
        end
      end else if (pick < 85) begin
        // Reads: anywhere in the address space, or near the bottom where scrolls land
        if ($urandom_range(0, 1))
          queue_word(OP_READ, $urandom_range(0, 255), $urandom_range(0, 2047));
        else
          queue_word(OP_READ, $urandom_range(0, 255), $urandom_range(CELLS - 2 * COLS, CELLS - 1));
        made++;
      end else if (pick < 92) begin
        ch = $urandom_range(0, 255);
        queue_word(OP_PUT, ch, $urandom_range(0, 2047));
        if (ch == CHAR_CR || ch == CHAR_LF || (ch >= PRINT_LO && ch <= PRINT_HI)) made++;
      end else if (pick < 99) begin
        queue_word(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 2047));
      end else begin
        queue_word(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
        made++;
      end
    end
  endtask

  // Hold until the block has drained: nothing left to send, nothing outstanding
  task automatic wait_drained();
    while (words_to_send.size() != 0 || pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the attribute register, read it back, update the shadow
  task automatic set_attribute(logic [ATTR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {{(APB_DW-ATTR_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[ATTR_W-1:0] !== value) begin
      if (mismatches < 10)
        $display("attribute readback: expected %02h got %02h", value, prdata[ATTR_W-1:0]);
      mismatches++;
    end
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    attr_now = value;
  endtask

  // Sender: offer words from the queue in bursts with random gaps between them
  int gap_left   = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        pending_results.push_back(console_step(words_to_send.pop_front()));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_DATA_W-IDX_W-CHAR_W){1'b0}}, words_to_send[0].idx, words_to_send[0].ch};
          s_tuser  <= words_to_send[0].op;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word against the oldest prediction, stall on a
  // pattern chosen by bits [9:7] of rx_cycle, and once hold off for a long stretch
  int   hold_left      = 0;
  bit   long_hold_done = 1'b0;
  int   rx_cycle       = 0;
  logic ready_next;
  console_result_t got_result;
  console_result_t exp_result;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_result.cursor     = m_tdata[10:0];
        got_result.cell_value = m_tdata[26:11];
        got_result.scrolled   = m_tdata[27];
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("result with nothing expected: cursor %0d cell %04h scrolled %0d",
                     got_result.cursor, got_result.cell_value, got_result.scrolled);
          mismatches++;
        end else begin
          exp_result = pending_results.pop_front();
          if (got_result !== exp_result) begin
            if (mismatches < 10)
              $display("result %0d: expected cursor %0d cell %04h scrolled %0d, got cursor %0d cell %04h scrolled %0d",
                       results_seen, exp_result.cursor, exp_result.cell_value, exp_result.scrolled,
                       got_result.cursor, got_result.cell_value, got_result.scrolled);
            mismatches++;
          end
        end
        results_seen++;
      end

      rx_cycle++;
      case (rx_cycle[9:7])
        3'd0, 3'd1: ready_next = 1'b1;
        3'd2, 3'd7: ready_next = 1'($urandom_range(0, 1));
        3'd3:       ready_next = ($urandom_range(0, 3) == 0);
        3'd4:       ready_next = ($urandom_range(0, 7) != 0);
        3'd5:       ready_next = rx_cycle[0];
        default:    ready_next = rx_cycle[3];
      endcase

      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // Starve the output long enough for the block to back up into its input
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        m_tready       <= 1'b0;
      end else begin
        m_tready <= ready_next;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  logic [ATTR_W-1:0] phase_attr [5];

  initial begin
    for (int i = 0; i < CELLS; i++) screen_copy[i] = RESET_CELL;
    cur_row  = 0;
    cur_col  = 0;
    attr_now = RESET_ATTR;
    phase_attr[0] = 8'hFF;
    phase_attr[1] = 8'h00;
    phase_attr[2] = ATTR_W'($urandom_range(0, 255));
    phase_attr[3] = 8'h1F;
    phase_attr[4] = ATTR_W'($urandom_range(0, 255));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset attribute: reset contents, read bounds,
    // printable edges, ignored bytes, CR, LF, the unused opcode and clear
    queue_word(OP_READ, 8'h00, 0);
    queue_word(OP_READ, 8'hFF, CELLS - 1);
    queue_word(OP_READ, 8'h00, CELLS);
    queue_word(OP_READ, 8'h00, 2047);
    queue_word(OP_PUT, PRINT_LO, 0);
    queue_word(OP_PUT, PRINT_HI, 0);
    queue_word(OP_PUT, 8'h41, 0);
    queue_word(OP_PUT, 8'h80, 2047);
    queue_word(OP_PUT, 8'hFF, 0);
    queue_word(OP_PUT, 8'h00, 0);
    queue_word(OP_PUT, 8'h1F, 0);
    queue_word(OP_PUT, CHAR_CR, 0);
    queue_word(OP_PUT, CHAR_LF, 0);
    queue_word(OP_NONE, 8'hFF, 2047);
    queue_word(OP_READ, 8'h00, 0);
    queue_word(OP_READ, 8'h00, 2);
    queue_word(OP_PUT, 8'h5A, 2047);
    queue_word(OP_READ, 8'h00, COLS);
    queue_word(OP_CLEAR, 8'hFF, 2047);
    queue_word(OP_READ, 8'h00, 1);
    queue_word(OP_PUT, 8'h7E, 0);
    queue_word(OP_READ, 8'h00, 0);
    wait_drained();

    // Random phases, each at its own attribute, written with the block drained
    for (int p = 0; p < 5; p++) begin
      set_attribute(phase_attr[p]);
      queue_random_words(180);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
